FILE: src/button_press_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// Button press classifier assertion macros
// Shared assertion helpers. Simulation gets the checks; synthesis gets
// empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button press classifier: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button press classifier: next-cycle check failed");
`else
`define BPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Button press classifier package
// Field widths, codes, constants and the structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int VOLT_W     = 12;
    localparam int TIME_W     = 32;
    localparam int WIN_W      = 16;
    localparam int THROTTLE_W = 16;
    localparam int SPEED_W    = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = VOLT_W + TIME_W + THROTTLE_W + SPEED_W;
    localparam int IN_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RESULT_W   = 2 + 2 + SPEED_W + 1 + 1;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Cruise may only engage above this electrical speed.
    localparam logic signed [SPEED_W-1:0] MIN_CRUISE_RPM = 19'sd900;
    // One percent of full scale in Q15, rounded down.
    localparam logic signed [THROTTLE_W-1:0] THROTTLE_IDLE_MAX = 16'sd327;

    localparam logic [VOLT_W-1:0] RST_PRESS_THRESHOLD = 12'd2048;
    localparam logic [WIN_W-1:0]  RST_SHORT_MIN_MS    = 16'd50;
    localparam logic [WIN_W-1:0]  RST_SHORT_MAX_MS    = 16'd500;
    localparam logic [WIN_W-1:0]  RST_LONG_MIN_MS     = 16'd1000;
    localparam logic [WIN_W-1:0]  RST_LONG_MAX_MS     = 16'd2500;
    localparam logic [WIN_W-1:0]  RST_HOLD_TIMEOUT_MS = 16'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_THRESHOLD     = 3'd0,
        CFG_SHORT_MIN_MS        = 3'd1,
        CFG_SHORT_MAX_MS        = 3'd2,
        CFG_LONG_MIN_MS         = 3'd3,
        CFG_LONG_MAX_MS         = 3'd4,
        CFG_HOLD_TIMEOUT_MS     = 3'd5,
        CFG_DRIVE_MODES_ENABLE  = 3'd6,
        CFG_POWER_CRUISE_ENABLE = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_CONT  = 2'd3
    } t_press_event;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_RELEASE   = 2'd1,
        CMD_SET_SPEED = 2'd2,
        CMD_STOP      = 2'd3
    } t_motor_cmd;

    typedef struct packed {
        logic [VOLT_W-1:0] press_threshold;
        logic [WIN_W-1:0]  short_min_ms;
        logic [WIN_W-1:0]  short_max_ms;
        logic [WIN_W-1:0]  long_min_ms;
        logic [WIN_W-1:0]  long_max_ms;
        logic [WIN_W-1:0]  hold_timeout_ms;
        logic              drive_modes_enable;
        logic              power_cruise_enable;
    } t_cfg;

    // Packed so that the last field lands in the lowest bits.
    typedef struct packed {
        logic signed [SPEED_W-1:0]    motor_speed;
        logic signed [THROTTLE_W-1:0] throttle_level;
        logic [TIME_W-1:0]            now_ms;
        logic [VOLT_W-1:0]            voltage_code;
    } t_sample;

    typedef struct packed {
        logic                      race_mode;
        logic                      cruise_on;
        logic signed [SPEED_W-1:0] speed_target;
        t_motor_cmd                motor_command;
        t_press_event              press_event;
    } t_result;

endpackage

`default_nettype wire

FILE: src/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button press classifier configuration registers
// Write-only register file loaded through a plain index/data port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bpc_pkg::t_cfg                         o_cfg
);

    bpc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_threshold     <= bpc_pkg::RST_PRESS_THRESHOLD;
            r_cfg.short_min_ms        <= bpc_pkg::RST_SHORT_MIN_MS;
            r_cfg.short_max_ms        <= bpc_pkg::RST_SHORT_MAX_MS;
            r_cfg.long_min_ms         <= bpc_pkg::RST_LONG_MIN_MS;
            r_cfg.long_max_ms         <= bpc_pkg::RST_LONG_MAX_MS;
            r_cfg.hold_timeout_ms     <= bpc_pkg::RST_HOLD_TIMEOUT_MS;
            r_cfg.drive_modes_enable  <= 1'b0;
            r_cfg.power_cruise_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (bpc_pkg::t_cfg_idx'(i_cfg_idx))
                bpc_pkg::CFG_PRESS_THRESHOLD: begin
                    r_cfg.press_threshold <= i_cfg_data[bpc_pkg::VOLT_W-1:0];
                end
                bpc_pkg::CFG_SHORT_MIN_MS: begin
                    r_cfg.short_min_ms <= i_cfg_data[bpc_pkg::WIN_W-1:0];
                end
                bpc_pkg::CFG_SHORT_MAX_MS: begin
                    r_cfg.short_max_ms <= i_cfg_data[bpc_pkg::WIN_W-1:0];
                end
                bpc_pkg::CFG_LONG_MIN_MS: begin
                    r_cfg.long_min_ms <= i_cfg_data[bpc_pkg::WIN_W-1:0];
                end
                bpc_pkg::CFG_LONG_MAX_MS: begin
                    r_cfg.long_max_ms <= i_cfg_data[bpc_pkg::WIN_W-1:0];
                end
                bpc_pkg::CFG_HOLD_TIMEOUT_MS: begin
                    r_cfg.hold_timeout_ms <= i_cfg_data[bpc_pkg::WIN_W-1:0];
                end
                bpc_pkg::CFG_DRIVE_MODES_ENABLE: begin
                    r_cfg.drive_modes_enable <= i_cfg_data[0];
                end
                bpc_pkg::CFG_POWER_CRUISE_ENABLE: begin
                    r_cfg.power_cruise_enable <= i_cfg_data[0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/bpc_step.sv
// ----------------------------------------------------------------------------
// Button press classifier step logic
// Holds the press tracking and cruise state and classifies one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_step (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire bpc_pkg::t_cfg    i_cfg,
    input  wire bpc_pkg::t_sample i_sample,
    output bpc_pkg::t_result      o_result
);

    logic [bpc_pkg::TIME_W-1:0]         r_start;
    logic                               r_was_pressed;
    logic                               r_locked;
    logic                               r_cruise;
    logic signed [bpc_pkg::SPEED_W-1:0] r_cruise_speed;
    logic                               r_race;

    logic [bpc_pkg::TIME_W-1:0]         n_start;
    logic                               n_locked;
    logic                               n_cruise;
    logic signed [bpc_pkg::SPEED_W-1:0] n_cruise_speed;
    logic                               n_race;

    logic                               w_pressed;
    logic [bpc_pkg::TIME_W-1:0]         w_elapsed;
    logic                               w_in_long;
    logic                               w_in_short;
    bpc_pkg::t_press_event              w_event;
    bpc_pkg::t_motor_cmd                w_cmd;

    // The time stamp wraps, so the difference is taken modulo 2^32.
    assign w_pressed  = i_sample.voltage_code < i_cfg.press_threshold;
    assign w_elapsed  = i_sample.now_ms - r_start;
    assign w_in_long  = (w_elapsed >= {16'd0, i_cfg.long_min_ms}) &&
                        (w_elapsed <= {16'd0, i_cfg.long_max_ms});
    assign w_in_short = (w_elapsed >  {16'd0, i_cfg.short_min_ms}) &&
                        (w_elapsed <= {16'd0, i_cfg.short_max_ms});

    always_comb begin
        n_start        = r_start;
        n_locked       = r_locked;
        n_cruise       = r_cruise;
        n_cruise_speed = r_cruise_speed;
        n_race         = r_race;
        w_event        = bpc_pkg::EV_NONE;
        w_cmd          = bpc_pkg::CMD_NONE;
        if (w_pressed) begin
            if (!r_locked) begin
                if (r_was_pressed) begin
                    if (w_elapsed > {16'd0, i_cfg.hold_timeout_ms}) begin
                        n_locked = 1'b1;
                        w_event  = bpc_pkg::EV_CONT;
                        w_cmd    = bpc_pkg::CMD_STOP;
                    end
                end else begin
                    n_start = i_sample.now_ms;
                end
            end
        end else if (r_locked) begin
            n_locked = 1'b0;
        end else if (r_was_pressed) begin
            // The long window takes priority where the windows overlap.
            if (w_in_long) begin
                w_event = bpc_pkg::EV_LONG;
                if (i_cfg.drive_modes_enable) begin
                    n_race = ~r_race;
                end
            end else if (w_in_short) begin
                w_event = bpc_pkg::EV_SHORT;
                if (i_sample.throttle_level <= bpc_pkg::THROTTLE_IDLE_MAX) begin
                    if (r_cruise) begin
                        n_cruise = 1'b0;
                        w_cmd    = bpc_pkg::CMD_RELEASE;
                    end else if (i_sample.motor_speed > bpc_pkg::MIN_CRUISE_RPM) begin
                        n_cruise = 1'b1;
                        if (!i_cfg.power_cruise_enable) begin
                            n_cruise_speed = i_sample.motor_speed;
                            w_cmd          = bpc_pkg::CMD_SET_SPEED;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start        <= '0;
            r_was_pressed  <= 1'b0;
            r_locked       <= 1'b1;
            r_cruise       <= 1'b0;
            r_cruise_speed <= '0;
            r_race         <= 1'b0;
        end else if (i_en) begin
            r_start        <= n_start;
            r_was_pressed  <= w_pressed;
            r_locked       <= n_locked;
            r_cruise       <= n_cruise;
            r_cruise_speed <= n_cruise_speed;
            r_race         <= n_race;
        end
    end

    assign o_result.press_event   = w_event;
    assign o_result.motor_command = w_cmd;
    assign o_result.speed_target  = n_cruise_speed;
    assign o_result.cruise_on     = n_cruise;
    assign o_result.race_mode     = n_race;

endmodule

`default_nettype wire

FILE: src/button_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// Button press classifier unit
// Classifies button samples into short, long and continuous presses and
// issues cruise and stop commands to the motor controller.
// ----------------------------------------------------------------------------
// Usage: each request on the s_axis channel is one sample of the button line
// with its millisecond time stamp, the throttle and the motor speed. Every
// sample produces exactly one request on the m_axis channel carrying the
// press event, the motor command and the cruise and drive-mode flags as they
// stand after that sample.
// An accepted sample is captured in the input register; its result moves to
// the output register, raising m_axis_tvalid, once that register is free or
// being emptied. The block takes one sample per cycle unless the receiver
// stalls: the press and cruise state is a single register loop closed through
// one compare and select step, so each sample sees the state left by the one
// before it. Reset (synchronous, active low) loads the register defaults,
// empties both registers and starts the block locked, so a button held at
// power-up is ignored until its first released sample.
// When the receiver stalls, the result holds in the output register; one more
// sample can wait in the input register, after which s_axis_tready drops.
// Configuration writes take effect at the next edge and are expected only
// while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_unit_defines.svh"

module button_press_classifier_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port: register index and data, no read-back.
    input  wire logic                               i_cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Sample input.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata from bit 0: voltage_code[11:0], now_ms[43:12],
    // throttle_level[59:44], motor_speed[78:60], zero pad[79].
    input  wire logic [bpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Result output.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata from bit 0: press_event[1:0], motor_command[3:2],
    // speed_target[22:4], cruise_on[23], race_mode[24], zero pad[31:25].
    output logic [bpc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    bpc_pkg::t_cfg    w_cfg;
    bpc_pkg::t_result w_result;

    logic             r_in_valid;
    bpc_pkg::t_sample r_in;
    logic             r_out_valid;
    bpc_pkg::t_result r_out;
    logic             w_advance;

    // The sample in the input register moves on when the output register is
    // free or is being emptied this cycle; the state advances with it.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    bpc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bpc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_cfg    (w_cfg),
        .i_sample (r_in),
        .o_result (w_result)
    );

    // Input register: valid bit under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= bpc_pkg::t_sample'(s_axis_tdata[bpc_pkg::SAMPLE_W-1:0]);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bpc_pkg::OUT_TDATA_W - bpc_pkg::RESULT_W){1'b0}}, r_out};

    // A continuous press always comes with the stop command.
    `BPC_ASSERT_IMPLY(a_cont_stops, i_clk, i_rst_n,
        r_out_valid && (r_out.press_event == bpc_pkg::EV_CONT),
        r_out.motor_command == bpc_pkg::CMD_STOP)
    // Setting a speed target only happens when cruise is switched on.
    `BPC_ASSERT_IMPLY(a_set_speed_cruise, i_clk, i_rst_n,
        r_out_valid && (r_out.motor_command == bpc_pkg::CMD_SET_SPEED),
        r_out.cruise_on && (r_out.press_event == bpc_pkg::EV_SHORT))
    // A sample held back by a stalled output is not dropped.
    `BPC_ASSERT_NEXT(a_in_kept, i_clk, i_rst_n,
        r_in_valid && !w_advance,
        r_in_valid)
    // A sample that advances always shows up in the output register.
    `BPC_ASSERT_NEXT(a_advance_out, i_clk, i_rst_n,
        w_advance,
        r_out_valid)

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button press classifier unit testbench
// Drives button samples through the sample stream and checks every result
// against a fixed expectation or a cycle-free predictor of the press,
// cruise and drive-mode logic. A directed table covers the reset state, the
// window edges, the throttle and speed limits, the continuous-press lockout
// and time stamp wrap. Random press sequences then run under several
// register settings and idling patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench;

    import bpc_pkg::*;

    // A result stays out of reach of a stalled receiver for this long at most;
    // the watchdog limit sits well above it and above any random sender gap.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STUCK_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 4;

    // One row of the directed table. Rows with fixed_exp set carry their
    // expected result; all other rows are checked against the predictor.
    typedef struct {
        logic [VOLT_W-1:0]            volt;
        logic [TIME_W-1:0]            ms;
        logic signed [THROTTLE_W-1:0] throttle;
        logic signed [SPEED_W-1:0]    erpm;
        bit                           fixed_exp;
        t_press_event                 ev;
        t_motor_cmd                   cmd;
        logic signed [SPEED_W-1:0]    target;
        logic                         cruise;
        logic                         race;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor copy of the registers and of the press and cruise state.
    t_cfg                      cfg_now;
    logic [TIME_W-1:0]         hold_start_ms;
    logic                      held_last;
    logic                      button_locked;
    logic                      cruise_engaged;
    logic signed [SPEED_W-1:0] cruise_erpm;
    logic                      race_selected;

    t_result pending_results[$];
    t_row    directed_rows[25];
    int      mismatch_count = 0;
    int      stuck_cycles = 0;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;
    logic    hold_off_request = 1'b0;
    logic [TIME_W-1:0] ms_clock = '0;
    t_result got_res;
    t_result want_res;

    button_press_classifier_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata from bit 0: voltage_code, now_ms, throttle_level, motor_speed.
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata from bit 0: press_event, motor_command, speed_target,
        // cruise_on, race_mode.
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: one call per accepted sample, in acceptance order. The state
    // only ever moves on a sample, so calling it at the acceptance edge sees
    // exactly the state the block holds for that sample.
    // ------------------------------------------------------------------------
    function automatic t_result classify_sample(input t_sample smp);
        t_result           res;
        logic              pressed;
        logic [TIME_W-1:0] held_ms;
        res.press_event   = EV_NONE;
        res.motor_command = CMD_NONE;
        pressed = smp.voltage_code < cfg_now.press_threshold;
        // Elapsed time wraps with the time stamp, so plain unsigned subtraction.
        held_ms = smp.now_ms - hold_start_ms;
        if (pressed) begin
            if (!button_locked) begin
                if (held_last) begin
                    // Held past the timeout: lock out and stop the motor. The
                    // cruise flag and the latched speed are left alone.
                    if (held_ms > TIME_W'(cfg_now.hold_timeout_ms)) begin
                        button_locked     = 1'b1;
                        res.press_event   = EV_CONT;
                        res.motor_command = CMD_STOP;
                    end
                end else begin
                    hold_start_ms = smp.now_ms;
                end
            end
        end else if (button_locked) begin
            // The first released sample only clears the lockout.
            button_locked = 1'b0;
        end else if (held_last) begin
            // The long window is checked first, so it wins where they overlap.
            if (held_ms >= TIME_W'(cfg_now.long_min_ms) &&
                held_ms <= TIME_W'(cfg_now.long_max_ms)) begin
                res.press_event = EV_LONG;
                if (cfg_now.drive_modes_enable)
                    race_selected = ~race_selected;
            end else if (held_ms > TIME_W'(cfg_now.short_min_ms) &&
                         held_ms <= TIME_W'(cfg_now.short_max_ms)) begin
                res.press_event = EV_SHORT;
                if (smp.throttle_level <= THROTTLE_IDLE_MAX) begin
                    if (cruise_engaged) begin
                        cruise_engaged    = 1'b0;
                        res.motor_command = CMD_RELEASE;
                    end else if (smp.motor_speed > MIN_CRUISE_RPM) begin
                        cruise_engaged = 1'b1;
                        // With power cruise the flag alone is set.
                        if (!cfg_now.power_cruise_enable) begin
                            cruise_erpm       = smp.motor_speed;
                            res.motor_command = CMD_SET_SPEED;
                        end
                    end
                end
            end
        end
        held_last        = pressed;
        res.speed_target = cruise_erpm;
        res.cruise_on    = cruise_engaged;
        res.race_mode    = race_selected;
        return res;
    endfunction

    // Builds a sample on the requested side of the current threshold, with a
    // throttle and a speed drawn around their decision points.
    function automatic t_sample make_sample(input bit pressed, input logic [TIME_W-1:0] ms);
        t_sample smp;
        smp.now_ms = ms;
        if (pressed && cfg_now.press_threshold != 0)
            smp.voltage_code = VOLT_W'($urandom_range(0, cfg_now.press_threshold - 1));
        else if (!pressed)
            smp.voltage_code = VOLT_W'($urandom_range(cfg_now.press_threshold, 4095));
        else
            smp.voltage_code = VOLT_W'($urandom);
        case ($urandom_range(0, 4))
            0:       smp.throttle_level = THROTTLE_IDLE_MAX;
            1:       smp.throttle_level = THROTTLE_IDLE_MAX + 16'sd1;
            2:       smp.throttle_level = THROTTLE_W'($urandom);
            default: smp.throttle_level = THROTTLE_W'(327 - int'($urandom_range(0, 33095)));
        endcase
        case ($urandom_range(0, 4))
            0:       smp.motor_speed = MIN_CRUISE_RPM;
            1:       smp.motor_speed = MIN_CRUISE_RPM + 19'sd1;
            2:       smp.motor_speed = SPEED_W'($urandom);
            default: smp.motor_speed = SPEED_W'($urandom_range(901, 262143));
        endcase
        return smp;
    endfunction

    // Hold times aimed at the edges of each window, plus some far off.
    function automatic logic [TIME_W-1:0] pick_hold_time();
        logic [TIME_W-1:0] smin;
        logic [TIME_W-1:0] smax;
        logic [TIME_W-1:0] lmin;
        logic [TIME_W-1:0] lmax;
        logic [TIME_W-1:0] tmo;
        logic [TIME_W-1:0] dur;
        smin = TIME_W'(cfg_now.short_min_ms);
        smax = TIME_W'(cfg_now.short_max_ms);
        lmin = TIME_W'(cfg_now.long_min_ms);
        lmax = TIME_W'(cfg_now.long_max_ms);
        tmo  = TIME_W'(cfg_now.hold_timeout_ms);
        case ($urandom_range(0, 15))
            0:       dur = smin;
            1:       dur = smin + 1;
            2:       dur = smax;
            3:       dur = smax + 1;
            4:       dur = lmin - 1;
            5:       dur = lmin;
            6:       dur = lmax;
            7:       dur = lmax + 1;
            8:       dur = tmo;
            9:       dur = tmo + 1;
            10, 11:  dur = smin + 1 + $urandom_range(0, smax - smin);
            12, 13:  dur = lmin + $urandom_range(0, lmax - lmin);
            14:      dur = $urandom_range(0, 70000);
            default: dur = $urandom;
        endcase
        return dur;
    endfunction

    // Offers one sample with the current sender idling, waits for the
    // request to be taken, then records what it should produce.
    task automatic send_sample(input t_sample smp, input bit fixed_exp, input t_result fixed_res);
        t_result predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(smp);
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = classify_sample(smp);
        pending_results.push_back(fixed_exp ? fixed_res : predicted);
    endtask

    // Writes one register with random junk above its width, which the block
    // must mask off.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] wdata;
        wdata = CFG_DATA_W'($urandom);
        case (idx) inside
            CFG_PRESS_THRESHOLD:                              wdata[VOLT_W-1:0] = value[VOLT_W-1:0];
            CFG_DRIVE_MODES_ENABLE, CFG_POWER_CRUISE_ENABLE: wdata[0] = value[0];
            default:                                          wdata = value;
        endcase
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= wdata;
        @(posedge i_clk);
        case (idx)
            CFG_PRESS_THRESHOLD:     cfg_now.press_threshold     = wdata[VOLT_W-1:0];
            CFG_SHORT_MIN_MS:        cfg_now.short_min_ms        = wdata;
            CFG_SHORT_MAX_MS:        cfg_now.short_max_ms        = wdata;
            CFG_LONG_MIN_MS:         cfg_now.long_min_ms         = wdata;
            CFG_LONG_MAX_MS:         cfg_now.long_max_ms         = wdata;
            CFG_HOLD_TIMEOUT_MS:     cfg_now.hold_timeout_ms     = wdata;
            CFG_DRIVE_MODES_ENABLE:  cfg_now.drive_modes_enable  = wdata[0];
            CFG_POWER_CRUISE_ENABLE: cfg_now.power_cruise_enable = wdata[0];
            default: ;
        endcase
    endtask

    // Stops offering, then waits until every result is back and the two
    // pipeline registers have surely emptied.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly complete press sequences: a press, a few pressed samples inside
    // the hold, sometimes an overhold into the lockout, then the release.
    // The rest is loose samples at random times and levels.
    task automatic run_phase(input int n_items);
        int                issued;
        int                extra;
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] dur;
        t_sample           smp;
        issued = 0;
        while (issued < n_items) begin
            if ($urandom_range(0, 99) < 75) begin
                ms_clock = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom)
                                                        : ms_clock + $urandom_range(1, 400);
                start_ms = ms_clock;
                dur = pick_hold_time();
                send_sample(make_sample(1'b1, start_ms), 1'b0, t_result'('0));
                extra = $urandom_range(0, 2);
                repeat (extra) begin
                    send_sample(make_sample(1'b1, start_ms + $urandom_range(0, dur)),
                                1'b0, t_result'('0));
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_sample(make_sample(1'b1, start_ms +
                                            TIME_W'(cfg_now.hold_timeout_ms) + 1 +
                                            $urandom_range(0, 50)),
                                1'b0, t_result'('0));
                    issued++;
                end
                ms_clock = start_ms + dur;
                send_sample(make_sample(1'b0, ms_clock), 1'b0, t_result'('0));
                issued += 2 + extra;
            end else begin
                ms_clock = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                                       : ms_clock + $urandom_range(0, 3000);
                smp = make_sample(1'($urandom_range(0, 1)), ms_clock);
                if ($urandom_range(0, 2) == 0)
                    smp.voltage_code = VOLT_W'($urandom);
                send_sample(smp, 1'b0, t_result'('0));
                issued++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure at the current stall rate. On request it
    // holds off for a long stretch so the block fills and stalls its input.
    // ------------------------------------------------------------------------
    initial begin : sink_side
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_request <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = t_result'(m_axis_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result with no expectation pending: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.press_event !== want_res.press_event) begin
                    $error("press_event: expected %0d, got %0d",
                           want_res.press_event, got_res.press_event);
                    mismatch_count++;
                end
                if (got_res.motor_command !== want_res.motor_command) begin
                    $error("motor_command: expected %0d, got %0d",
                           want_res.motor_command, got_res.motor_command);
                    mismatch_count++;
                end
                if (got_res.speed_target !== want_res.speed_target) begin
                    $error("speed_target: expected %0d, got %0d",
                           want_res.speed_target, got_res.speed_target);
                    mismatch_count++;
                end
                if (got_res.cruise_on !== want_res.cruise_on) begin
                    $error("cruise_on: expected %0d, got %0d",
                           want_res.cruise_on, got_res.cruise_on);
                    mismatch_count++;
                end
                if (got_res.race_mode !== want_res.race_mode) begin
                    $error("race_mode: expected %0d, got %0d",
                           want_res.race_mode, got_res.race_mode);
                    mismatch_count++;
                end
            end
        end
    end

    // Cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_cfg    next_cfg;
        t_result fixed_res;
        int      lo;
        int      hi;

        // Directed rows, all under the reset register values. The first rows
        // show the power-up lockout: a pressed sample is ignored and the next
        // released one only unlocks. Then the short window at its lower edge, the
        // throttle idle limit, the minimum cruise speed, a long press with
        // drive modes off, a hold exactly at and just past the timeout, the
        // lockout release, and a press across the time stamp wrap.
        directed_rows = '{
            '{12'd0,    32'd0,         16'sd0,    19'sd0,     1'b1, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd5,         16'sd0,    19'sd0,     1'b1, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd2047, 32'd100,       16'sd0,    19'sd0,     1'b1, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd2048, 32'd300,       16'h8000,  19'h3FFFF,  1'b1, EV_SHORT, CMD_SET_SPEED,
              19'h3FFFF, 1'b1, 1'b0},
            '{12'd0,    32'd1000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd1200,      16'sd327,  19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd2000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd2200,      16'sd328,  19'sd5000,  1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd3000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd3200,      16'sd0,    19'sd900,   1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd4000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd4050,      16'sd0,    19'sd5000,  1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd5000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd5051,      16'sd0,    19'sd901,   1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd6000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd7000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd8000,      16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd11000,     16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd11001,     16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'd12000,     16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd12010,     16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'hFFFF_FF00, 16'sd0,    19'sd0,     1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'h0000_0010, 16'sd0,    19'h40000,  1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd0,    32'hFFFF_FFFF, 16'hFFFF,  19'h7FFFF,  1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0},
            '{12'd4095, 32'd2600,      16'h7FFF,  19'h3FFFF,  1'b0, EV_NONE,  CMD_NONE,
              19'sd0, 1'b0, 1'b0}
        };

        // Reset values of the registers and of the press state.
        cfg_now.press_threshold     = RST_PRESS_THRESHOLD;
        cfg_now.short_min_ms        = RST_SHORT_MIN_MS;
        cfg_now.short_max_ms        = RST_SHORT_MAX_MS;
        cfg_now.long_min_ms         = RST_LONG_MIN_MS;
        cfg_now.long_max_ms         = RST_LONG_MAX_MS;
        cfg_now.hold_timeout_ms     = RST_HOLD_TIMEOUT_MS;
        cfg_now.drive_modes_enable  = 1'b0;
        cfg_now.power_cruise_enable = 1'b0;
        hold_start_ms  = '0;
        held_last      = 1'b0;
        button_locked  = 1'b1;
        cruise_engaged = 1'b0;
        cruise_erpm    = '0;
        race_selected  = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            fixed_res.press_event   = directed_rows[r].ev;
            fixed_res.motor_command = directed_rows[r].cmd;
            fixed_res.speed_target  = directed_rows[r].target;
            fixed_res.cruise_on     = directed_rows[r].cruise;
            fixed_res.race_mode     = directed_rows[r].race;
            send_sample('{motor_speed:    directed_rows[r].erpm,
                          throttle_level: directed_rows[r].throttle,
                          now_ms:         directed_rows[r].ms,
                          voltage_code:   directed_rows[r].volt},
                        directed_rows[r].fixed_exp, fixed_res);
        end
        ms_clock = 32'd20000;

        // Random phases. Each one writes every register, then runs with its
        // own idling pattern: none, sender idle, receiver stalling, or both.
        for (int p = 0; p < 8; p++) begin
            drain();
            case (p)
                // Reset-like windows with drive modes on.
                0: next_cfg = '{RST_PRESS_THRESHOLD, RST_SHORT_MIN_MS, RST_SHORT_MAX_MS,
                                RST_LONG_MIN_MS, RST_LONG_MAX_MS, RST_HOLD_TIMEOUT_MS,
                                1'b1, 1'b0};
                // Everything at its top value: short never fits, long only at
                // exactly the top.
                1: next_cfg = '{12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                1'b1, 1'b1};
                // Threshold zero: nothing ever counts as pressed.
                2: next_cfg = '{12'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0};
                // Zero windows: a long press at zero hold, and any hold over
                // zero turns continuous.
                3: next_cfg = '{12'd4095, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
                default: begin
                    lo = $urandom_range(0, 300);
                    hi = lo + $urandom_range(0, 1500);
                    next_cfg.press_threshold = VOLT_W'($urandom_range(1, 4095));
                    next_cfg.short_min_ms    = WIN_W'(lo);
                    next_cfg.short_max_ms    = WIN_W'(hi);
                    // Now and then the long window overlaps the short one.
                    if ($urandom_range(0, 4) == 0)
                        lo = $urandom_range(0, hi);
                    else
                        lo = hi + $urandom_range(0, 2000);
                    hi = lo + $urandom_range(0, 3000);
                    next_cfg.long_min_ms     = WIN_W'(lo);
                    next_cfg.long_max_ms     = WIN_W'(hi);
                    next_cfg.hold_timeout_ms = ($urandom_range(0, 4) == 0) ? WIN_W'($urandom)
                                               : WIN_W'(hi + $urandom_range(0, 3000));
                    next_cfg.drive_modes_enable  = 1'($urandom_range(0, 1));
                    next_cfg.power_cruise_enable = (p == 5) ? 1'b1 : 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(CFG_PRESS_THRESHOLD,     CFG_DATA_W'(next_cfg.press_threshold));
            write_reg(CFG_SHORT_MIN_MS,        next_cfg.short_min_ms);
            write_reg(CFG_SHORT_MAX_MS,        next_cfg.short_max_ms);
            write_reg(CFG_LONG_MIN_MS,         next_cfg.long_min_ms);
            write_reg(CFG_LONG_MAX_MS,         next_cfg.long_max_ms);
            write_reg(CFG_HOLD_TIMEOUT_MS,     next_cfg.hold_timeout_ms);
            write_reg(CFG_DRIVE_MODES_ENABLE,  CFG_DATA_W'(next_cfg.drive_modes_enable));
            write_reg(CFG_POWER_CRUISE_ENABLE, CFG_DATA_W'(next_cfg.power_cruise_enable));
            i_cfg_we <= 1'b0;

            src_idle_pct   = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 20 : 0;
            sink_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 20 : 0;
            // The first phase starts with the receiver held off while the
            // sender keeps offering at full rate.
            if (p == 0)
                hold_off_request <= 1'b1;
            run_phase((p == 2) ? 30 : 110);
        end

        drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
